/* design/h264fua_pkg.sv */
// shared types, constants and helpers for the h264 fu-a packetizer
// no dependencies; imported by every module of the block
`default_nettype none

package h264fua_pkg;

  localparam int LENGTH_BITS  = 20;
  localparam int PAYLOAD_BITS = 11;

  localparam logic [PAYLOAD_BITS-1:0] MAX_PAYLOAD_RESET = PAYLOAD_BITS'(1420);
  localparam logic [PAYLOAD_BITS-1:0] MIN_LIMIT         = PAYLOAD_BITS'(16);
  localparam logic [PAYLOAD_BITS-1:0] FU_OVERHEAD       = PAYLOAD_BITS'(2);

  // nal / fu-a header fields
  localparam logic [7:0] NAL_FNRI_MASK = 8'he0;
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [7:0] FU_A_TYPE     = 8'd28;
  localparam logic [7:0] FU_S_BIT      = 8'h80;
  localparam logic [7:0] FU_E_BIT      = 8'h40;

  localparam logic [7:0] START_CODE_ONE = 8'h01;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // one nal byte handed from the front end to the packet builder
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;       // final byte of the frame
    logic        fits;       // bytes left from here fit in one fu packet
    logic        frag;       // frame is sent as fu-a fragments
    logic        nal_first;  // first nal byte of the frame
    logic        input_end;  // last byte caused by its input word
    logic        channel;
    logic [31:0] stamp;
  } push_t;

  function automatic logic [PAYLOAD_BITS-1:0] eff_limit(input logic [PAYLOAD_BITS-1:0] m);
    return (m < MIN_LIMIT) ? MIN_LIMIT : m;
  endfunction

  // data bytes per fu packet after the two header bytes
  function automatic logic [PAYLOAD_BITS-1:0] room_of(input logic [PAYLOAD_BITS-1:0] m);
    return eff_limit(m) - FU_OVERHEAD;
  endfunction

endpackage

`default_nettype wire

/* design/h264_nal_fua_packetizer_top.sv */
// h264 fu-a packetizer, one frame byte per input word, one payload byte per output word
// an accepted byte passes through the byte queue and the output register before its first output word
// throughput: 1 byte per cycle while the output is not stalled; each fu packet also emits its indicator and header,
//   and flushing held zero bytes stalls the input while each zero is written to the single-write byte queue
// reset: synchronous active-high rst clears frame state, queue and output; max_payload = 1420
// depends on h264fua_pkg, h264fua_front, h264fua_queue, h264fua_back
`default_nettype none

module h264_nal_fua_packetizer_top
  import h264fua_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    max_payload_wen,
  input  wire logic [PAYLOAD_BITS-1:0] max_payload_wdata,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [63:0]             s_axis_tdata,  // data_byte, frame_length, stamp, zero pad
  input  wire logic                    s_axis_tuser,  // channel
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [39:0]                  m_axis_tdata,  // out_byte, out_stamp
  output logic                         m_axis_tlast,  // end_of_packet
  output logic [2:0]                   m_axis_tuser   // marker, out_channel, run_end
);

  logic [PAYLOAD_BITS-1:0] max_payload;

  push_t       fe_push;
  logic        fe_valid;
  logic        fe_ready;
  push_t       q_data;
  logic        q_valid;
  logic        q_ready;
  logic [7:0]  out_byte;
  logic        marker;
  logic        out_channel;
  logic [31:0] out_stamp;
  logic        run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (max_payload_wen) begin
      max_payload <= max_payload_wdata;
    end
  end

  h264fua_front u_front (
    .clk          (clk),
    .rst          (rst),
    .max_payload  (max_payload),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .data_byte    (s_axis_tdata[7:0]),
    .frame_length (s_axis_tdata[LENGTH_BITS+7:8]),
    .channel      (s_axis_tuser),
    .stamp        (s_axis_tdata[LENGTH_BITS+39:LENGTH_BITS+8]),
    .push_valid   (fe_valid),
    .push_ready   (fe_ready),
    .push         (fe_push)
  );

  h264fua_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fe_valid),
    .wr_ready (fe_ready),
    .wr_data  (fe_push),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  h264fua_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_payload   (max_payload),
    .op_valid      (q_valid),
    .op_ready      (q_ready),
    .op            (q_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (out_byte),
    .end_of_packet (m_axis_tlast),
    .marker        (marker),
    .out_channel   (out_channel),
    .out_stamp     (out_stamp),
    .run_end       (run_end)
  );

  assign m_axis_tdata = {out_stamp, out_byte};
  assign m_axis_tuser = {run_end, out_channel, marker};

endmodule

`default_nettype wire

/* design/h264fua_front.sv */
// front end: start code stripping, frame tracking, held zero flush
// depends on h264fua_pkg
`default_nettype none

module h264fua_front
  import h264fua_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [PAYLOAD_BITS-1:0] max_payload,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              data_byte,
  input  wire logic [LENGTH_BITS-1:0]  frame_length,
  input  wire logic                    channel,
  input  wire logic [31:0]             stamp,
  output logic                         push_valid,
  input  wire logic                    push_ready,
  output push_t                        push
);

  logic                   in_frame;
  logic                   start_done;
  logic                   pushed;
  logic [1:0]             held_count;
  logic [LENGTH_BITS-1:0] remaining;
  logic                   frag;

  logic                   flushing;
  logic [1:0]             flush_dist;
  logic [7:0]             flush_byte;
  logic [LENGTH_BITS-1:0] flush_after;
  logic                   flush_ch;
  logic [31:0]            flush_st;

  logic                    accept;
  logic [LENGTH_BITS-1:0]  len_eff;
  logic [LENGTH_BITS-1:0]  rem_next;
  logic                    frag_next;
  logic                    sd_eff;
  logic [1:0]              hc_eff;
  logic                    pushed_eff;
  logic                    do_strip;
  logic                    do_hold;
  logic                    do_flush;
  logic [PAYLOAD_BITS-1:0] room;
  logic [LENGTH_BITS:0]    dist_after;
  logic [1:0]              wr_dist;
  logic [7:0]              wr_byte;
  logic [LENGTH_BITS-1:0]  wr_after;

  assign room     = room_of(max_payload);
  assign in_ready = !flushing && push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    len_eff    = (frame_length == '0) ? LENGTH_BITS'(1) : frame_length;
    sd_eff     = in_frame && start_done;
    hc_eff     = in_frame ? held_count : 2'd0;
    pushed_eff = in_frame && pushed;
    if (!in_frame) begin
      rem_next  = len_eff - LENGTH_BITS'(1);
      frag_next = len_eff > LENGTH_BITS'(eff_limit(max_payload));
    end else begin
      rem_next  = (remaining != '0) ? remaining - LENGTH_BITS'(1) : remaining;
      frag_next = frag;
    end
    do_strip = !sd_eff && (data_byte == START_CODE_ONE) && (hc_eff >= 2'd2);
    do_hold  = !sd_eff && !do_strip && (data_byte == ZERO_BYTE) && (hc_eff != 2'd3)
               && (rem_next != '0);
    do_flush = !sd_eff && !do_strip && !do_hold;
  end

  // the pushed byte sits dist bytes before the current input byte
  always_comb begin
    if (flushing) begin
      wr_dist  = flush_dist;
      wr_byte  = flush_byte;
      wr_after = flush_after;
    end else begin
      wr_dist  = do_flush ? hc_eff : 2'd0;
      wr_byte  = data_byte;
      wr_after = rem_next;
    end
    dist_after = {1'b0, wr_after} + (LENGTH_BITS+1)'(wr_dist);

    push.data_byte = (wr_dist != 2'd0) ? ZERO_BYTE : wr_byte;
    push.last      = (dist_after == '0);
    push.fits      = dist_after < (LENGTH_BITS+1)'(room);
    push.frag      = flushing ? frag : frag_next;
    push.nal_first = flushing ? 1'b0 : !pushed_eff;
    push.input_end = (wr_dist == 2'd0);
    push.channel   = flushing ? flush_ch : channel;
    push.stamp     = flushing ? flush_st : stamp;

    push_valid = flushing || (accept && (sd_eff || do_flush));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      start_done <= 1'b0;
      pushed     <= 1'b0;
      held_count <= 2'd0;
      remaining  <= '0;
      frag       <= 1'b0;
      flushing   <= 1'b0;
      flush_dist <= 2'd0;
    end else begin
      if (flushing && push_ready) begin
        if (flush_dist == 2'd0) begin
          flushing <= 1'b0;
        end else begin
          flush_dist <= flush_dist - 2'd1;
        end
      end
      if (accept) begin
        remaining  <= rem_next;
        frag       <= frag_next;
        start_done <= sd_eff;
        held_count <= hc_eff;
        pushed     <= pushed_eff;
        if (sd_eff) begin
          pushed <= 1'b1;
        end else if (do_strip) begin
          start_done <= 1'b1;
          held_count <= 2'd0;
        end else if (do_hold) begin
          held_count <= hc_eff + 2'd1;
        end else begin
          start_done <= 1'b1;
          held_count <= 2'd0;
          pushed     <= 1'b1;
          if (hc_eff != 2'd0) begin
            flushing   <= 1'b1;
            flush_dist <= hc_eff - 2'd1;
          end
        end
        if (rem_next == '0) begin
          in_frame   <= 1'b0;
          start_done <= 1'b0;
          held_count <= 2'd0;
          pushed     <= 1'b0;
        end else begin
          in_frame <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flush_byte  <= data_byte;
      flush_after <= rem_next;
      flush_ch    <= channel;
      flush_st    <= stamp;
    end
  end

endmodule

`default_nettype wire

/* design/h264fua_queue.sv */
// short fifo of nal bytes between the front end and the packet builder
// depends on h264fua_pkg
`default_nettype none

module h264fua_queue
  import h264fua_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  wire push_t wr_data,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output push_t      rd_data
);

  push_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = (count != (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* design/h264fua_back.sv */
// packet builder: fu-a header insertion, packet cutting, output register
// depends on h264fua_pkg
`default_nettype none

module h264fua_back
  import h264fua_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [PAYLOAD_BITS-1:0] max_payload,
  input  wire logic                    op_valid,
  output logic                         op_ready,
  input  wire push_t                   op,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [7:0]                   out_byte,
  output logic                         end_of_packet,
  output logic                         marker,
  output logic                         out_channel,
  output logic [31:0]                  out_stamp,
  output logic                         run_end
);

  typedef enum logic [1:0] {
    PH_START,
    PH_FU,
    PH_DATA
  } phase_t;

  phase_t                  phase;
  phase_t                  phase_next;
  logic                    header_seen;
  logic [7:0]              saved_nal_header;
  logic                    first_packet;
  logic [PAYLOAD_BITS-1:0] packet_fill;

  logic                    hs_eff;
  logic                    fp_eff;
  logic [PAYLOAD_BITS-1:0] fill_eff;
  logic [PAYLOAD_BITS-1:0] fill_inc;
  logic [PAYLOAD_BITS-1:0] room;
  logic                    pkt_end;
  logic                    emit;
  logic                    pop;
  logic                    capture;
  logic                    step;
  logic [7:0]              byte_next;
  logic                    eop_next;
  logic                    marker_next;
  logic                    run_end_next;

  assign room = room_of(max_payload);

  always_comb begin
    hs_eff   = op.nal_first ? 1'b0 : header_seen;
    fp_eff   = op.nal_first ? 1'b1 : first_packet;
    fill_eff = op.nal_first ? '0 : packet_fill;
    fill_inc = fill_eff + PAYLOAD_BITS'(1);
    pkt_end  = op.last || (fill_inc >= room);

    emit         = 1'b1;
    pop          = 1'b0;
    capture      = 1'b0;
    phase_next   = phase;
    byte_next    = op.data_byte;
    eop_next     = 1'b0;
    marker_next  = 1'b0;
    run_end_next = 1'b0;

    priority if (!op.frag) begin
      pop          = 1'b1;
      eop_next     = op.last;
      marker_next  = op.last;
      run_end_next = op.input_end;
    end else if (!hs_eff) begin
      // nal header byte is only kept for the fu indicator and header
      emit    = 1'b0;
      pop     = 1'b1;
      capture = 1'b1;
    end else if ((fill_eff == '0) && (phase == PH_START)) begin
      byte_next  = (saved_nal_header & NAL_FNRI_MASK) | FU_A_TYPE;
      phase_next = PH_FU;
    end else if (phase == PH_FU) begin
      byte_next  = (saved_nal_header & NAL_TYPE_MASK) | (fp_eff ? FU_S_BIT : 8'h00)
                   | (op.fits ? FU_E_BIT : 8'h00);
      phase_next = PH_DATA;
    end else begin
      pop          = 1'b1;
      eop_next     = pkt_end;
      marker_next  = op.last;
      run_end_next = op.input_end;
      phase_next   = PH_START;
    end

    step     = op_valid && (!emit || !out_valid || out_ready);
    op_ready = step && pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      header_seen      <= 1'b0;
      saved_nal_header <= 8'h00;
      first_packet     <= 1'b1;
      packet_fill      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (step && emit) begin
        out_valid     <= 1'b1;
        out_byte      <= byte_next;
        end_of_packet <= eop_next;
        marker        <= marker_next;
        run_end       <= run_end_next;
        out_channel   <= op.channel;
        out_stamp     <= op.stamp;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        phase <= phase_next;
        if (pop && op.frag) begin
          header_seen <= 1'b1;
          if (capture) begin
            saved_nal_header <= op.data_byte;
            first_packet     <= fp_eff;
            packet_fill      <= fill_eff;
          end else begin
            first_packet <= 1'b0;
            packet_fill  <= pkt_end ? '0 : fill_inc;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
